### hdl/sgi_pkg.sv
// Shared types, widths and register codes for the 2D segment intersection block.
// No dependencies; used by every module under hdl/.
package sgi_pkg;

  localparam int CRD_W = 32;      // coordinate width
  localparam int DIF_W = 33;      // exact coordinate difference
  localparam int PRD_W = 66;      // product of two differences
  localparam int CRS_W = 67;      // cross product
  localparam int MAG_W = 66;      // magnitude of a cross product
  localparam int THR_W = 32;
  localparam int TOL_W = 13;
  localparam int PRM_W = 17;      // output parameter width
  localparam int CFG_W = 32;
  localparam int IDX_W = 2;
  localparam int PARAM_FRAC_BITS_DEF = 16;

  localparam logic [IDX_W-1:0] REG_PARALLEL_THRESHOLD = 2'd0;
  localparam logic [IDX_W-1:0] REG_PARAM_TOLERANCE    = 2'd1;

  // Quotient width: covers 1.0 plus the largest tolerance.
  function automatic int quot_w(input int pfb);
    return ((pfb > TOL_W) ? pfb : TOL_W) + 1;
  endfunction

  // Side data that rides along the divider stages.
  typedef struct packed {
    logic                    par;
    logic                    neg_t;
    logic                    neg_s;
    logic                    ovf_t;
    logic                    ovf_s;
    logic signed [CRD_W-1:0] p1x;
    logic signed [CRD_W-1:0] p1y;
    logic signed [DIF_W-1:0] ux;
    logic signed [DIF_W-1:0] uy;
  } side_t;

endpackage

### hdl/segment_intersection_2d.sv
// Channels: in_* carries one segment pair per beat (valid/ready); out_* carries
// one result per beat (valid/ready). cfg_we/cfg_index/cfg_wdata write the
// parallel threshold (index 0) and the parameter tolerance (index 1);
// other indexes are ignored. Write configuration only while idle.
// Throughput: one beat per cycle while the output is not stalled. Pipeline:
// 5 front stages, one divider stage per quotient bit (max(PARAM_FRAC_BITS,13)+1,
// 17 at the default), and 3 back stages; the divider chain is the longest part.
// The whole pipeline advances together; when out_valid is high and out_ready
// is low every stage holds and in_ready drops, so nothing is lost or repeated.
// Bubbles flow through as cleared valid bits.
// Reset (synchronous, active low) empties the pipeline and loads threshold 1,
// tolerance 0. Parallel pairs and misses give hit 0 with all fields zero.
// Depends on sgi_pkg, sgi_front, sgi_div_step and sgi_back.
module segment_intersection_2d #(
  parameter int PARAM_FRAC_BITS = sgi_pkg::PARAM_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [sgi_pkg::CRD_W-1:0] in_p_start_x,
  input  logic signed [sgi_pkg::CRD_W-1:0] in_p_start_y,
  input  logic signed [sgi_pkg::CRD_W-1:0] in_p_end_x,
  input  logic signed [sgi_pkg::CRD_W-1:0] in_p_end_y,
  input  logic signed [sgi_pkg::CRD_W-1:0] in_q_start_x,
  input  logic signed [sgi_pkg::CRD_W-1:0] in_q_start_y,
  input  logic signed [sgi_pkg::CRD_W-1:0] in_q_end_x,
  input  logic signed [sgi_pkg::CRD_W-1:0] in_q_end_y,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_hit,
  output logic [sgi_pkg::PRM_W-1:0]        out_param_first,
  output logic [sgi_pkg::PRM_W-1:0]        out_param_second,
  output logic signed [sgi_pkg::CRD_W-1:0] out_cross_x,
  output logic signed [sgi_pkg::CRD_W-1:0] out_cross_y,
  input  logic                             cfg_we,
  input  logic [sgi_pkg::IDX_W-1:0]        cfg_index,
  input  logic [sgi_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int QW  = sgi_pkg::quot_w(PARAM_FRAC_BITS);
  localparam int DDW = sgi_pkg::MAG_W + QW - PARAM_FRAC_BITS;

  logic en;
  logic [sgi_pkg::THR_W-1:0] cfg_thr_r;
  logic [sgi_pkg::TOL_W-1:0] cfg_tol_r;

  logic           dv     [QW+1];
  logic [DDW-1:0] d_a    [QW+1];
  logic [DDW-1:0] rt_a   [QW+1];
  logic [DDW-1:0] rs_a   [QW+1];
  logic [QW-1:0]  qt_a   [QW+1];
  logic [QW-1:0]  qs_a   [QW+1];
  sgi_pkg::side_t side_a [QW+1];

  // advance everything unless the output beat is stuck
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_thr_r <= sgi_pkg::THR_W'(1);
      cfg_tol_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sgi_pkg::REG_PARALLEL_THRESHOLD: cfg_thr_r <= cfg_wdata[sgi_pkg::THR_W-1:0];
        sgi_pkg::REG_PARAM_TOLERANCE:    cfg_tol_r <= cfg_wdata[sgi_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  sgi_front #(.PFB(PARAM_FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .p1x       (in_p_start_x),
    .p1y       (in_p_start_y),
    .p2x       (in_p_end_x),
    .p2y       (in_p_end_y),
    .q1x       (in_q_start_x),
    .q1y       (in_q_start_y),
    .q2x       (in_q_end_x),
    .q2y       (in_q_end_y),
    .thr       (cfg_thr_r),
    .out_valid (dv[0]),
    .out_d     (d_a[0]),
    .out_rt    (rt_a[0]),
    .out_rs    (rs_a[0]),
    .out_side  (side_a[0])
  );

  assign qt_a[0] = '0;
  assign qs_a[0] = '0;

  for (genvar i = 0; i < QW; i++) begin : g_div
    sgi_div_step #(.PFB(PARAM_FRAC_BITS)) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (dv[i]),
      .in_d      (d_a[i]),
      .in_rt     (rt_a[i]),
      .in_rs     (rs_a[i]),
      .in_qt     (qt_a[i]),
      .in_qs     (qs_a[i]),
      .in_side   (side_a[i]),
      .out_valid (dv[i+1]),
      .out_d     (d_a[i+1]),
      .out_rt    (rt_a[i+1]),
      .out_rs    (rs_a[i+1]),
      .out_qt    (qt_a[i+1]),
      .out_qs    (qs_a[i+1]),
      .out_side  (side_a[i+1])
    );
  end

  sgi_back #(.PFB(PARAM_FRAC_BITS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (dv[QW]),
    .qt           (qt_a[QW]),
    .qs           (qs_a[QW]),
    .rnz_t        (rt_a[QW] != '0),
    .rnz_s        (rs_a[QW] != '0),
    .side         (side_a[QW]),
    .tol          (cfg_tol_r),
    .out_valid    (out_valid),
    .hit          (out_hit),
    .param_first  (out_param_first),
    .param_second (out_param_second),
    .cross_x      (out_cross_x),
    .cross_y      (out_cross_y)
  );

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_param_first == '0 && out_param_second == '0 &&
                                 out_cross_x == '0 && out_cross_y == '0))
    else $error("miss result carries nonzero fields");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_hit) &&
                                   $stable(out_cross_x) && $stable(out_cross_y)))
    else $error("result changed while stalled");
`endif

endmodule

### hdl/sgi_front.sv
// Front end: differences, products, cross products, magnitudes and range checks.
// Five register stages; depends on sgi_pkg.
module sgi_front #(
  parameter int PFB = sgi_pkg::PARAM_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [sgi_pkg::CRD_W-1:0]     p1x,
  input  logic signed [sgi_pkg::CRD_W-1:0]     p1y,
  input  logic signed [sgi_pkg::CRD_W-1:0]     p2x,
  input  logic signed [sgi_pkg::CRD_W-1:0]     p2y,
  input  logic signed [sgi_pkg::CRD_W-1:0]     q1x,
  input  logic signed [sgi_pkg::CRD_W-1:0]     q1y,
  input  logic signed [sgi_pkg::CRD_W-1:0]     q2x,
  input  logic signed [sgi_pkg::CRD_W-1:0]     q2y,
  input  logic [sgi_pkg::THR_W-1:0]            thr,
  output logic                                 out_valid,
  output logic [sgi_pkg::MAG_W+sgi_pkg::quot_w(PFB)-PFB-1:0] out_d,
  output logic [sgi_pkg::MAG_W+sgi_pkg::quot_w(PFB)-PFB-1:0] out_rt,
  output logic [sgi_pkg::MAG_W+sgi_pkg::quot_w(PFB)-PFB-1:0] out_rs,
  output sgi_pkg::side_t                       out_side
);

  localparam int QW  = sgi_pkg::quot_w(PFB);
  localparam int IB  = QW - PFB;
  localparam int DDW = sgi_pkg::MAG_W + IB;
  localparam int DW  = sgi_pkg::DIF_W;
  localparam int PW  = sgi_pkg::PRD_W;
  localparam int XW  = sgi_pkg::CRS_W;
  localparam int MW  = sgi_pkg::MAG_W;
  localparam int CW  = sgi_pkg::CRD_W;

  // stage 1
  logic v1_r;
  logic signed [CW-1:0] p1x1_r, p1y1_r;
  logic signed [DW-1:0] ux_r, uy_r, vx_r, vy_r, wx_r, wy_r;
  // stage 2
  logic v2_r;
  logic signed [CW-1:0] p1x2_r, p1y2_r;
  logic signed [DW-1:0] ux2_r, uy2_r;
  logic signed [PW-1:0] m_uv1_r, m_uv2_r, m_vw1_r, m_vw2_r, m_uw1_r, m_uw2_r;
  // stage 3
  logic v3_r;
  logic signed [CW-1:0] p1x3_r, p1y3_r;
  logic signed [DW-1:0] ux3_r, uy3_r;
  logic signed [XW-1:0] det_r, ct_r, cs_r;
  // stage 4
  logic v4_r;
  logic signed [CW-1:0] p1x4_r, p1y4_r;
  logic signed [DW-1:0] ux4_r, uy4_r;
  logic [MW-1:0] dmag_r, at_r, as_r;
  logic neg_t4_r, neg_s4_r;
  // stage 5
  logic v5_r;
  logic [DDW-1:0] d5_r, rt5_r, rs5_r;
  sgi_pkg::side_t side5_r;

  logic signed [XW-1:0] det_nxt, ct_nxt, cs_nxt;
  logic [XW-1:0] det_abs, ct_abs, cs_abs;
  logic [DDW-1:0] d_sh;
  logic par_nxt;

  assign det_nxt = XW'(m_uv1_r) - XW'(m_uv2_r);
  assign ct_nxt  = XW'(m_vw1_r) - XW'(m_vw2_r);
  assign cs_nxt  = XW'(m_uw1_r) - XW'(m_uw2_r);

  assign det_abs = det_r[XW-1] ? XW'(-det_r) : XW'(det_r);
  assign ct_abs  = ct_r[XW-1]  ? XW'(-ct_r)  : XW'(ct_r);
  assign cs_abs  = cs_r[XW-1]  ? XW'(-cs_r)  : XW'(cs_r);

  assign d_sh = {dmag_r, {IB{1'b0}}};
  assign par_nxt = (dmag_r == '0) ||
                   ((dmag_r[MW-1:sgi_pkg::THR_W] == '0) &&
                    (dmag_r[sgi_pkg::THR_W-1:0] < thr));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1x1_r <= p1x;
      p1y1_r <= p1y;
      ux_r   <= DW'(p2x) - DW'(p1x);
      uy_r   <= DW'(p2y) - DW'(p1y);
      vx_r   <= DW'(q2x) - DW'(q1x);
      vy_r   <= DW'(q2y) - DW'(q1y);
      wx_r   <= DW'(p1x) - DW'(q1x);
      wy_r   <= DW'(p1y) - DW'(q1y);

      p1x2_r  <= p1x1_r;
      p1y2_r  <= p1y1_r;
      ux2_r   <= ux_r;
      uy2_r   <= uy_r;
      m_uv1_r <= ux_r * vy_r;
      m_uv2_r <= uy_r * vx_r;
      m_vw1_r <= vx_r * wy_r;
      m_vw2_r <= vy_r * wx_r;
      m_uw1_r <= ux_r * wy_r;
      m_uw2_r <= uy_r * wx_r;

      p1x3_r <= p1x2_r;
      p1y3_r <= p1y2_r;
      ux3_r  <= ux2_r;
      uy3_r  <= uy2_r;
      det_r  <= det_nxt;
      ct_r   <= ct_nxt;
      cs_r   <= cs_nxt;

      // quotient sign is the xor of numerator and determinant signs
      p1x4_r   <= p1x3_r;
      p1y4_r   <= p1y3_r;
      ux4_r    <= ux3_r;
      uy4_r    <= uy3_r;
      dmag_r   <= det_abs[MW-1:0];
      at_r     <= ct_abs[MW-1:0];
      as_r     <= cs_abs[MW-1:0];
      neg_t4_r <= ct_r[XW-1] ^ det_r[XW-1];
      neg_s4_r <= cs_r[XW-1] ^ det_r[XW-1];

      d5_r          <= d_sh;
      rt5_r         <= DDW'(at_r);
      rs5_r         <= DDW'(as_r);
      side5_r.par   <= par_nxt;
      side5_r.neg_t <= neg_t4_r;
      side5_r.neg_s <= neg_s4_r;
      side5_r.ovf_t <= DDW'(at_r) >= d_sh;
      side5_r.ovf_s <= DDW'(as_r) >= d_sh;
      side5_r.p1x   <= p1x4_r;
      side5_r.p1y   <= p1y4_r;
      side5_r.ux    <= ux4_r;
      side5_r.uy    <= uy4_r;
    end
  end

  assign out_valid = v5_r;
  assign out_d     = d5_r;
  assign out_rt    = rt5_r;
  assign out_rs    = rs5_r;
  assign out_side  = side5_r;

endmodule

### hdl/sgi_div_step.sv
// One quotient bit of the two parallel restoring dividers, one register stage.
// Depends on sgi_pkg.
module sgi_div_step #(
  parameter int PFB = sgi_pkg::PARAM_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [sgi_pkg::MAG_W+sgi_pkg::quot_w(PFB)-PFB-1:0] in_d,
  input  logic [sgi_pkg::MAG_W+sgi_pkg::quot_w(PFB)-PFB-1:0] in_rt,
  input  logic [sgi_pkg::MAG_W+sgi_pkg::quot_w(PFB)-PFB-1:0] in_rs,
  input  logic [sgi_pkg::quot_w(PFB)-1:0]      in_qt,
  input  logic [sgi_pkg::quot_w(PFB)-1:0]      in_qs,
  input  sgi_pkg::side_t                       in_side,
  output logic                                 out_valid,
  output logic [sgi_pkg::MAG_W+sgi_pkg::quot_w(PFB)-PFB-1:0] out_d,
  output logic [sgi_pkg::MAG_W+sgi_pkg::quot_w(PFB)-PFB-1:0] out_rt,
  output logic [sgi_pkg::MAG_W+sgi_pkg::quot_w(PFB)-PFB-1:0] out_rs,
  output logic [sgi_pkg::quot_w(PFB)-1:0]      out_qt,
  output logic [sgi_pkg::quot_w(PFB)-1:0]      out_qs,
  output sgi_pkg::side_t                       out_side
);

  localparam int QW  = sgi_pkg::quot_w(PFB);
  localparam int DDW = sgi_pkg::MAG_W + QW - PFB;

  logic v_r;
  logic [DDW-1:0] d_r, rt_r, rs_r;
  logic [QW-1:0] qt_r, qs_r;
  sgi_pkg::side_t side_r;

  logic [DDW:0] rt2, rs2, dx;
  logic ge_t, ge_s;

  assign dx   = {1'b0, in_d};
  assign rt2  = {in_rt, 1'b0};
  assign rs2  = {in_rs, 1'b0};
  assign ge_t = rt2 >= dx;
  assign ge_s = rs2 >= dx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= in_d;
      rt_r   <= ge_t ? DDW'(rt2 - dx) : DDW'(rt2);
      rs_r   <= ge_s ? DDW'(rs2 - dx) : DDW'(rs2);
      qt_r   <= {in_qt[QW-2:0], ge_t};
      qs_r   <= {in_qs[QW-2:0], ge_s};
      side_r <= in_side;
    end
  end

  assign out_valid = v_r;
  assign out_d     = d_r;
  assign out_rt    = rt_r;
  assign out_rs    = rs_r;
  assign out_qt    = qt_r;
  assign out_qs    = qs_r;
  assign out_side  = side_r;

endmodule

### hdl/sgi_back.sv
// Back end: tolerance window, clamping, point multiply and saturating add.
// Three register stages, the last one is the output register; depends on sgi_pkg.
module sgi_back #(
  parameter int PFB = sgi_pkg::PARAM_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [sgi_pkg::quot_w(PFB)-1:0]      qt,
  input  logic [sgi_pkg::quot_w(PFB)-1:0]      qs,
  input  logic                                 rnz_t,
  input  logic                                 rnz_s,
  input  sgi_pkg::side_t                       side,
  input  logic [sgi_pkg::TOL_W-1:0]            tol,
  output logic                                 out_valid,
  output logic                                 hit,
  output logic [sgi_pkg::PRM_W-1:0]            param_first,
  output logic [sgi_pkg::PRM_W-1:0]            param_second,
  output logic signed [sgi_pkg::CRD_W-1:0]     cross_x,
  output logic signed [sgi_pkg::CRD_W-1:0]     cross_y
);

  localparam int QW = sgi_pkg::quot_w(PFB);
  localparam int TW = PFB + 1;
  localparam int DW = sgi_pkg::DIF_W;
  localparam int CW = sgi_pkg::CRD_W;
  localparam int MW = DW + TW + 1;          // signed product width
  localparam int FW = MW + 1 - PFB;         // rounded offset width
  localparam int OW = FW + 1;               // point before saturation
  localparam logic [QW-1:0] ONE = QW'(1) << PFB;

  logic [QW-1:0] tol_q, hi_q;
  logic pass_t, pass_s;
  logic [TW-1:0] tc_nxt, sc_nxt;

  // stage B1
  logic v1_r, hit1_r;
  logic [TW-1:0] tc_r, sc_r;
  logic signed [CW-1:0] p1x1_r, p1y1_r;
  logic signed [DW-1:0] ux1_r, uy1_r;
  // stage B2
  logic v2_r, hit2_r;
  logic [TW-1:0] tc2_r, sc2_r;
  logic signed [CW-1:0] p1x2_r, p1y2_r;
  logic signed [MW-1:0] px_r, py_r;
  // stage B3
  logic v3_r, hit3_r;
  logic [sgi_pkg::PRM_W-1:0] pf_r, ps_r;
  logic signed [CW-1:0] cx_r, cy_r;

  logic signed [MW:0] sx, sy;
  logic signed [OW-1:0] ptx, pty;

  function automatic logic signed [CW-1:0] sat(input logic signed [OW-1:0] v);
    logic signed [OW-1:0] hi_b, lo_b;
    hi_b = OW'({1'b0, {(CW-1){1'b1}}});
    lo_b = -hi_b - OW'(1);
    if (v > hi_b) begin
      return CW'(hi_b);
    end else if (v < lo_b) begin
      return CW'(lo_b);
    end
    return CW'(v);
  endfunction

  assign tol_q = QW'(tol);
  assign hi_q  = ONE + tol_q;

  // negative side: t = -(q + rem!=0), high side: t = q plus a fraction when rem!=0
  assign pass_t = !side.ovf_t &&
                  (side.neg_t ? ((qt < tol_q) || ((qt == tol_q) && !rnz_t))
                              : ((qt < hi_q)  || ((qt == hi_q)  && !rnz_t)));
  assign pass_s = !side.ovf_s &&
                  (side.neg_s ? ((qs < tol_q) || ((qs == tol_q) && !rnz_s))
                              : ((qs < hi_q)  || ((qs == hi_q)  && !rnz_s)));

  assign tc_nxt = side.neg_t ? '0 : ((qt > ONE) ? TW'(ONE) : TW'(qt));
  assign sc_nxt = side.neg_s ? '0 : ((qs > ONE) ? TW'(ONE) : TW'(qs));

  // round half up, then floor shift
  assign sx  = (MW+1)'(px_r) + ((MW+1)'(1) << (PFB-1));
  assign sy  = (MW+1)'(py_r) + ((MW+1)'(1) << (PFB-1));
  assign ptx = OW'(p1x2_r) + OW'($signed(sx[MW:PFB]));
  assign pty = OW'(p1y2_r) + OW'($signed(sy[MW:PFB]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit1_r <= !side.par && pass_t && pass_s;
      tc_r   <= tc_nxt;
      sc_r   <= sc_nxt;
      p1x1_r <= side.p1x;
      p1y1_r <= side.p1y;
      ux1_r  <= side.ux;
      uy1_r  <= side.uy;

      hit2_r <= hit1_r;
      tc2_r  <= tc_r;
      sc2_r  <= sc_r;
      p1x2_r <= p1x1_r;
      p1y2_r <= p1y1_r;
      px_r   <= MW'(ux1_r) * MW'($signed({1'b0, tc_r}));
      py_r   <= MW'(uy1_r) * MW'($signed({1'b0, tc_r}));

      hit3_r <= hit2_r;
      pf_r   <= hit2_r ? sgi_pkg::PRM_W'(tc2_r) : '0;
      ps_r   <= hit2_r ? sgi_pkg::PRM_W'(sc2_r) : '0;
      cx_r   <= hit2_r ? sat(ptx) : '0;
      cy_r   <= hit2_r ? sat(pty) : '0;
    end
  end

  assign out_valid    = v3_r;
  assign hit          = hit3_r;
  assign param_first  = pf_r;
  assign param_second = ps_r;
  assign cross_x      = cx_r;
  assign cross_y      = cy_r;

endmodule

### test/tb_top.sv
// Self-checking testbench for segment_intersection_2d: random and directed segment pairs,
// with a bit-exact predictor, a result checker and random handshake stalls.
// Depends on sgi_pkg and the segment_intersection_2d RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int LAT_WAIT = 40;
  localparam int WDOG_LIMIT = 20000;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;

  typedef struct {
    logic signed [31:0] psx, psy, pex, pey, qsx, qsy, qex, qey;
  } seg_pair_t;

  typedef struct {
    logic                      hit;
    logic [sgi_pkg::PRM_W-1:0] pf, ps;
    logic signed [31:0]        cx, cy;
  } isect_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_p_start_x = '0, in_p_start_y = '0, in_p_end_x = '0, in_p_end_y = '0;
  logic signed [31:0] in_q_start_x = '0, in_q_start_y = '0, in_q_end_x = '0, in_q_end_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit;
  logic [sgi_pkg::PRM_W-1:0] out_param_first, out_param_second;
  logic signed [31:0] out_cross_x, out_cross_y;
  logic cfg_we = 1'b0;
  logic [sgi_pkg::IDX_W-1:0] cfg_index = '0;
  logic [sgi_pkg::CFG_W-1:0] cfg_wdata = '0;

  segment_intersection_2d dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // model copy of the registers
  logic [31:0] thr_q = 32'd1;
  logic [12:0] tol_q = '0;

  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int n_checked = 0;
  int n_hits = 0;
  int idle_cycles = 0;
  isect_t isect_q[$];

  function automatic logic signed [127:0] floor_quot(logic signed [127:0] n,
                                                      logic signed [127:0] d,
                                                      output logic rem_nz);
    logic signed [127:0] q, r;
    q = n / d;
    r = n % d;
    rem_nz = (r != 0);
    if (rem_nz && ((n < 0) != (d < 0))) q = q - 1;
    return q;
  endfunction

  function automatic logic in_window(logic signed [127:0] q, logic rem_nz);
    logic signed [127:0] hi;
    hi = (128'sd1 <<< FRAC) + $signed({115'd0, tol_q});
    if (q < -$signed({115'd0, tol_q})) return 1'b0;
    return (q < hi) || (q == hi && !rem_nz);
  endfunction

  function automatic logic signed [127:0] clamp_unit(logic signed [127:0] q);
    if (q < 0) return 0;
    if (q > (128'sd1 <<< FRAC)) return 128'sd1 <<< FRAC;
    return q;
  endfunction

  function automatic logic signed [31:0] on_line(logic signed [31:0] start,
                                                 logic signed [127:0] du,
                                                 logic signed [127:0] t);
    logic signed [127:0] r;
    r = start + ((du * t + (128'sd1 <<< (FRAC - 1))) >>> FRAC);
    if (r > 128'sd2147483647) r = 128'sd2147483647;
    if (r < -128'sd2147483648) r = -128'sd2147483648;
    return r[31:0];
  endfunction

  function automatic isect_t predict_isect(seg_pair_t sp);
    logic signed [127:0] ux, uy, vx, vy, wx, wy, det, adet, tq, sq, tc, sc;
    logic rt, rs;
    isect_t res;
    res = '{1'b0, '0, '0, '0, '0};
    ux = sp.pex - sp.psx;  uy = sp.pey - sp.psy;
    vx = sp.qex - sp.qsx;  vy = sp.qey - sp.qsy;
    wx = sp.psx - sp.qsx;  wy = sp.psy - sp.qsy;
    det = ux * vy - uy * vx;
    adet = (det < 0) ? -det : det;
    if (det == 0 || adet < $signed({96'd0, thr_q})) return res;
    tq = floor_quot((vx * wy - vy * wx) <<< FRAC, det, rt);
    sq = floor_quot((ux * wy - uy * wx) <<< FRAC, det, rs);
    if (!in_window(tq, rt) || !in_window(sq, rs)) return res;
    tc = clamp_unit(tq);
    sc = clamp_unit(sq);
    res.hit = 1'b1;
    res.pf = tc[sgi_pkg::PRM_W-1:0];
    res.ps = sc[sgi_pkg::PRM_W-1:0];
    res.cx = on_line(sp.psx, ux, tc);
    res.cy = on_line(sp.psy, uy, tc);
    return res;
  endfunction

  // Sample both channels mid-cycle; inputs and out_ready only move at the rising edge.
  always @(negedge clk) begin
    isect_t exp_r;
    if (rst_n) begin
      idle_cycles++;
      if (in_valid && in_ready) begin
        idle_cycles = 0;
        isect_q.insert(isect_q.size(),
                       predict_isect('{in_p_start_x, in_p_start_y, in_p_end_x,
                                       in_p_end_y, in_q_start_x, in_q_start_y,
                                       in_q_end_x, in_q_end_y}));
      end
      if (out_valid && out_ready) begin
        idle_cycles = 0;
        n_checked++;
        if (isect_q.size() == 0) begin
          $error("result beat with no pending expectation");
          errors++;
        end else begin
          exp_r = isect_q.pop_front();
          if (exp_r.hit) n_hits++;
          if (out_hit !== exp_r.hit) begin
            $error("hit: expected %0d, got %0d", exp_r.hit, out_hit); errors++;
          end
          if (out_param_first !== exp_r.pf) begin
            $error("param_first: expected %0d, got %0d", exp_r.pf, out_param_first);
            errors++;
          end
          if (out_param_second !== exp_r.ps) begin
            $error("param_second: expected %0d, got %0d", exp_r.ps, out_param_second);
            errors++;
          end
          if (out_cross_x !== exp_r.cx) begin
            $error("cross_x: expected %0d, got %0d", exp_r.cx, out_cross_x); errors++;
          end
          if (out_cross_y !== exp_r.cy) begin
            $error("cross_y: expected %0d, got %0d", exp_r.cy, out_cross_y); errors++;
          end
        end
      end
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles", WDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= stall_pct);

  // Called at a rising edge; returns at the edge that accepts the beat.
  task automatic send_pair(seg_pair_t sp);
    logic acc;
    // idle each cycle with the chosen odds
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_p_start_x <= sp.psx;  in_p_start_y <= sp.psy;
    in_p_end_x   <= sp.pex;  in_p_end_y   <= sp.pey;
    in_q_start_x <= sp.qsx;  in_q_start_y <= sp.qsy;
    in_q_end_x   <= sp.qex;  in_q_end_y   <= sp.qey;
    do begin
      @(negedge clk);
      acc = in_ready;
      @(posedge clk);
    end while (!acc);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (isect_q.size() != 0) @(posedge clk);
    repeat (LAT_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [sgi_pkg::IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sgi_pkg::REG_PARALLEL_THRESHOLD) thr_q = val;
    else if (idx == sgi_pkg::REG_PARAM_TOLERANCE) tol_q = val[12:0];
    @(posedge clk);
  endtask

  task automatic set_regs(logic [31:0] thr, logic [31:0] tol);
    drain();
    write_reg(sgi_pkg::REG_PARALLEL_THRESHOLD, thr);
    write_reg(sgi_pkg::REG_PARAM_TOLERANCE, tol);
  endtask

  function automatic logic signed [31:0] near(logic signed [31:0] base, int span);
    return base + ($signed($urandom_range(2 * span)) - span);
  endfunction

  function automatic seg_pair_t rand_pair();
    seg_pair_t sp;
    logic signed [63:0] mx, my;
    logic signed [31:0] cx, cy;
    int span, f, k, kind;
    kind = $urandom_range(99);
    span = 1 << (8 + 4 * $urandom_range(4));
    cx = $signed($urandom()) >>> $urandom_range(1, 8);
    cy = $signed($urandom()) >>> $urandom_range(1, 8);
    sp.psx = near(cx, span);  sp.psy = near(cy, span);
    sp.pex = near(cx, span);  sp.pey = near(cy, span);
    sp.qsx = near(cx, span);  sp.qsy = near(cy, span);
    sp.qex = near(cx, span);  sp.qey = near(cy, span);
    if (kind < 15) begin
      sp = '{$urandom(), $urandom(), $urandom(), $urandom(),
             $urandom(), $urandom(), $urandom(), $urandom()};
    end else if (kind < 60) begin
      // force a crossing: Q straddles a point on P
      f = $urandom_range(256);
      mx = sp.psx + (((64'(sp.pex) - sp.psx) * f) >>> 8);
      my = sp.psy + (((64'(sp.pey) - sp.psy) * f) >>> 8);
      sp.qsx = 32'(mx + (sp.qsx - cx));  sp.qsy = 32'(my + (sp.qsy - cy));
      sp.qex = 32'(mx - (sp.qsx - mx));  sp.qey = 32'(my - (sp.qsy - my));
    end else if (kind < 70) begin
      // parallel or collinear (k = 0 makes Q a single point)
      k = $urandom_range(3);
      sp.qex = sp.qsx + k * (sp.pex - sp.psx);
      sp.qey = sp.qsy + k * (sp.pey - sp.psy);
    end else if (kind < 80) begin
      // touch at the end of P
      sp.qsx = sp.pex;  sp.qsy = sp.pey;
    end
    return sp;
  endfunction

  task automatic test_directed();
    seg_pair_t list[$];
    list = '{
      '{-ONE, 0, ONE, 0, 0, -ONE, 0, ONE},
      '{0, 0, ONE, ONE, 0, ONE, ONE, 0},
      '{0, 0, ONE, 0, ONE, 0, ONE, ONE},
      '{0, 0, ONE, 0, 2 * ONE, -ONE, 2 * ONE, ONE},
      '{0, 0, ONE, 0, 0, ONE, ONE, ONE},
      '{0, 0, 2 * ONE, 0, ONE, 0, 3 * ONE, 0},
      '{0, 0, 0, 0, 0, 0, ONE, ONE},
      '{0, 0, 0, 0, 0, 0, 0, 0},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
        32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000},
      '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
      '{32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 0, 32'h8000_0000, 0, 32'h7FFF_FFFF},
      '{0, 0, 1, 0, 0, 0, 0, 1},
      '{0, 0, 3, 1, 0, 1, 3, 0},
      '{-1, -1, 1, 1, -1, 1, 1, -1},
      '{0, 0, ONE, 0, ONE + 1, -ONE, ONE + 1, ONE},
      '{0, 0, ONE, 0, -1, -ONE, -1, ONE},
      '{32'h7FFF_0000, 0, 32'h7FFF_FFFF, 0, 32'h7FFF_8000, -1, 32'h7FFF_8000, 1},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}
    };
    foreach (list[i]) send_pair(list[i]);
  endtask

  task automatic test_tolerance_edges();
    set_regs(32'd1, 32'd8191);
    repeat (6) send_pair(rand_pair());
    send_pair('{0, 0, ONE, 0, ONE + 8191, -ONE, ONE + 8191, ONE});
    send_pair('{0, 0, ONE, 0, -8191, -ONE, -8191, ONE});
    set_regs(32'd0, 32'd4096);
    send_pair('{0, 0, ONE, 0, 0, 0, 2 * ONE, 0});
    send_pair('{0, 0, ONE, 0, ONE + 4096, -ONE, ONE + 4096, ONE});
    send_pair('{0, 0, ONE, 0, ONE + 4097, -ONE, ONE + 4097, ONE});
    // writes to unused indexes must not disturb anything
    drain();
    write_reg(2'd2, $urandom());
    write_reg(2'd3, $urandom());
    repeat (6) send_pair(rand_pair());
  endtask

  task automatic test_random(int n_items, logic [31:0] thr, logic [31:0] tol,
                             int idle, int stall);
    set_regs(thr, tol);
    for (int i = 0; i < n_items; i++) begin
      idle_pct = idle;
      stall_pct = stall;
      // drop back to full speed for short stretches
      if ((i / 40) % 3 == 2) begin
        idle_pct = 0;
        stall_pct = 0;
      end
      send_pair(rand_pair());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_tolerance_edges();
    test_random(480, 32'd1, 32'd0, 0, 0);
    test_random(480, 32'hFFFF_FFFF, 32'd4096, 58, 0);
    test_random(480, $urandom(), $urandom_range(4096), 0, 58);
    test_random(480, 32'd0, 32'd8191, 23, 23);
    drain();
    $display("checked %0d result beats, %0d hits, across four register settings",
             n_checked, n_hits);
    $display("and four handshake pressure phases");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

### sim.f
hdl/sgi_pkg.sv
hdl/sgi_front.sv
hdl/sgi_div_step.sv
hdl/sgi_back.sv
hdl/segment_intersection_2d.sv
test/tb_top.sv
